// ----- hdl/emrq_pkg.sv -----
package emrq_pkg;

  localparam int unsigned NumStages = 6;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 32;

  typedef enum logic [CfgIdxW-1:0] {
    RegOffsetA    = 3'd0,
    RegOffsetB    = 3'd1,
    RegResultOff  = 3'd2,
    RegQuantMult  = 3'd3,
    RegQuantShift = 3'd4,
    RegClampLow   = 3'd5,
    RegClampHigh  = 3'd6
  } cfg_idx_e;

  localparam logic [30:0]        QuantMultRst = 31'h4000_0000;
  localparam logic signed [15:0] ClampLowRst  = -16'sd32768;
  localparam logic signed [15:0] ClampHighRst = 16'sd32767;

  typedef struct packed {
    logic signed [15:0] elem_a;
    logic signed [15:0] elem_b;
    logic               last_in;
  } in_t;

  typedef struct packed {
    logic signed [15:0] product_q;
    logic               last_out;
  } out_t;

  typedef struct packed {
    logic signed [15:0] offset_a;
    logic signed [15:0] offset_b;
    logic signed [15:0] result_offset;
    logic [30:0]        quant_multiplier;
    logic signed [5:0]  quant_shift;
    logic signed [15:0] clamp_low;
    logic signed [15:0] clamp_high;
  } cfg_t;

  typedef struct packed {
    logic [NumStages-1:0] en;
    logic [NumStages-1:0] valid;
  } ctrl_t;

  typedef struct packed {
    logic signed [31:0] shifted;
    logic               last;
  } mid_t;

endpackage

// ----- hdl/elementwise_mul_requant_s16.sv -----
// channel  | direction | handshake              | payload
// ---------+-----------+------------------------+------------------------------
// in       | input     | in_valid_i / in_stall_o   | in_data_i  (elem_a, elem_b, last_in)
// out      | output    | out_valid_o / out_stall_i | out_data_o (product_q, last_out)
// cfg      | input     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// One request per cycle sustained while out_stall_i is low; six register stages
// (offset add, 17x17 multiply, left shift, 32x31 multiply, rounding shift, offset+clamp).
// rst_ni clears the stage valid bits and loads the register reset values.
// A stall at the output holds only the stages that are full; empty stages keep filling.
// cfg_ready_o is always high; a write lands on the next edge.
module elementwise_mul_requant_s16 (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  emrq_pkg::in_t                  in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output emrq_pkg::out_t                 out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [emrq_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [emrq_pkg::CfgDataW-1:0]  cfg_data_i
);

  emrq_pkg::cfg_t  cfg;
  emrq_pkg::ctrl_t ctrl;
  emrq_pkg::mid_t  mid;

  emrq_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  emrq_pipe_ctrl u_pipe_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .ctrl_o      (ctrl)
  );

  emrq_mul_front u_mul_front (
    .clk_i     (clk_i),
    .ctrl_i    (ctrl),
    .cfg_i     (cfg),
    .in_data_i (in_data_i),
    .mid_o     (mid)
  );

  emrq_requant_back u_requant_back (
    .clk_i      (clk_i),
    .ctrl_i     (ctrl),
    .cfg_i      (cfg),
    .mid_i      (mid),
    .out_data_o (out_data_o)
  );

  a_free_flow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled while output drains");

  a_enter : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> ctrl.valid[0])
    else $error("accepted request did not enter first stage");

  a_full_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($countones(ctrl.valid) == emrq_pkg::NumStages) && out_stall_i |-> in_stall_o)
    else $error("full pipeline took a request under stall");

endmodule

// ----- hdl/emrq_cfg_regs.sv -----
module emrq_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [emrq_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [emrq_pkg::CfgDataW-1:0]  cfg_data_i,
  output emrq_pkg::cfg_t                 cfg_o
);

  emrq_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (emrq_pkg::cfg_idx_e'(cfg_index_i))
        emrq_pkg::RegOffsetA:    cfg_d.offset_a         = cfg_data_i[15:0];
        emrq_pkg::RegOffsetB:    cfg_d.offset_b         = cfg_data_i[15:0];
        emrq_pkg::RegResultOff:  cfg_d.result_offset    = cfg_data_i[15:0];
        emrq_pkg::RegQuantMult:  cfg_d.quant_multiplier = cfg_data_i[30:0];
        emrq_pkg::RegQuantShift: cfg_d.quant_shift      = cfg_data_i[5:0];
        emrq_pkg::RegClampLow:   cfg_d.clamp_low        = cfg_data_i[15:0];
        emrq_pkg::RegClampHigh:  cfg_d.clamp_high       = cfg_data_i[15:0];
        default:                 cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.offset_a         <= '0;
      cfg_q.offset_b         <= '0;
      cfg_q.result_offset    <= '0;
      cfg_q.quant_multiplier <= emrq_pkg::QuantMultRst;
      cfg_q.quant_shift      <= '0;
      cfg_q.clamp_low        <= emrq_pkg::ClampLowRst;
      cfg_q.clamp_high       <= emrq_pkg::ClampHighRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ----- hdl/emrq_pipe_ctrl.sv -----
module emrq_pipe_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output emrq_pkg::ctrl_t ctrl_o
);

  localparam int unsigned N = emrq_pkg::NumStages;

  logic [N-1:0] valid_q, valid_d;
  logic [N-1:0] en;

  always_comb begin
    en[N-1] = !valid_q[N-1] || !out_stall_i;
    for (int k = N - 2; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (en[0]) begin
      valid_d[0] = in_valid_i;
    end
    for (int k = 1; k < N; k++) begin
      if (en[k]) begin
        valid_d[k] = valid_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_stall_o   = !en[0];
  assign out_valid_o  = valid_q[N-1];
  assign ctrl_o.en    = en;
  assign ctrl_o.valid = valid_q;

endmodule

// ----- hdl/emrq_mul_front.sv -----
module emrq_mul_front (
  input  logic            clk_i,
  input  emrq_pkg::ctrl_t ctrl_i,
  input  emrq_pkg::cfg_t  cfg_i,
  input  emrq_pkg::in_t   in_data_i,
  output emrq_pkg::mid_t  mid_o
);

  logic signed [16:0] a0_q, a0_d, b0_q, b0_d;
  logic               last0_q;
  logic signed [33:0] prod;
  logic signed [31:0] p1_q;
  logic               last1_q;
  logic [4:0]         lshift;
  logic signed [31:0] v2_q, v2_d;
  logic               last2_q;

  always_comb begin
    a0_d   = 17'($signed(in_data_i.elem_a)) + 17'($signed(cfg_i.offset_a));
    b0_d   = 17'($signed(in_data_i.elem_b)) + 17'($signed(cfg_i.offset_b));
    prod   = a0_q * b0_q;
    lshift = (cfg_i.quant_shift > 6'sd0) ? cfg_i.quant_shift[4:0] : 5'd0;
    v2_d   = p1_q << lshift;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[0]) begin
      a0_q    <= a0_d;
      b0_q    <= b0_d;
      last0_q <= in_data_i.last_in;
    end
    if (ctrl_i.en[1]) begin
      p1_q    <= prod[31:0];
      last1_q <= last0_q;
    end
    if (ctrl_i.en[2]) begin
      v2_q    <= v2_d;
      last2_q <= last1_q;
    end
  end

  assign mid_o.shifted = v2_q;
  assign mid_o.last    = last2_q;

endmodule

// ----- hdl/emrq_requant_back.sv -----
module emrq_requant_back (
  input  logic            clk_i,
  input  emrq_pkg::ctrl_t ctrl_i,
  input  emrq_pkg::cfg_t  cfg_i,
  input  emrq_pkg::mid_t  mid_i,
  output emrq_pkg::out_t  out_data_o
);

  logic signed [63:0] mac;
  logic signed [31:0] h3_q;
  logic               last3_q;

  logic [5:0]         rshift;
  logic signed [32:0] x33, r33;
  logic [32:0]        mask, rem, thr;
  logic signed [32:0] r4_q, r4_d;
  logic               last4_q;

  logic signed [33:0] sum, lo34, hi34, c1, c2;
  logic signed [15:0] res5_q;
  logic               last5_q;

  always_comb begin
    mac = 64'(mid_i.shifted) * $signed({1'b0, cfg_i.quant_multiplier})
        + 64'sd1073741824;

    rshift = (cfg_i.quant_shift < 6'sd0) ? 6'(-cfg_i.quant_shift) : 6'd0;
    x33    = 33'(h3_q);
    r33    = x33 >>> rshift;
    mask   = (33'd1 << rshift) - 33'd1;
    rem    = x33 & mask;
    thr    = (mask >> 1) + 33'(h3_q[31]);
    r4_d   = r33 + ((rem > thr) ? 33'sd1 : 33'sd0);

    sum  = 34'(r4_q) + 34'(cfg_i.result_offset);
    lo34 = 34'(cfg_i.clamp_low);
    hi34 = 34'(cfg_i.clamp_high);
    c1   = (sum < lo34) ? lo34 : sum;
    c2   = (c1 > hi34) ? hi34 : c1;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[3]) begin
      h3_q    <= mac[62:31];
      last3_q <= mid_i.last;
    end
    if (ctrl_i.en[4]) begin
      r4_q    <= r4_d;
      last4_q <= last3_q;
    end
    if (ctrl_i.en[5]) begin
      res5_q  <= c2[15:0];
      last5_q <= last4_q;
    end
  end

  assign out_data_o.product_q = res5_q;
  assign out_data_o.last_out  = last5_q;

endmodule
